/* sv/i2cea_pkg.sv */
// ---------------------------------------------------------------------------
// I2C EEPROM access sequencer package
// Shared command codes, bus status codes, phase type and result entry type.
// ---------------------------------------------------------------------------
package i2cea_pkg;

    // Request and report kinds carried on the input tuser.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // Commands issued to the byte-level master.
    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_TX     = 3'd1,
        CMD_RXNACK = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_DONE   = 3'd4,
        CMD_REJECT = 3'd5
    } cmd_t;

    // Expected master status codes; only the upper five bits are compared.
    localparam logic [7:0] ST_START   = 8'h08;
    localparam logic [7:0] ST_SLAW_OK = 8'h18;
    localparam logic [7:0] ST_DATA_OK = 8'h28;
    localparam logic [7:0] ST_RSTART  = 8'h10;
    localparam logic [7:0] ST_SLAR_OK = 8'h40;
    localparam logic [7:0] ST_RX_NACK = 8'h58;
    localparam logic [7:0] STATUS_MASK = 8'hF8;

    // Device address base for the serial EEPROM.
    localparam logic [7:0] DEV_BASE = 8'hA0;

    // Access phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_START  = 8'b0000_0010,
        PH_SLAW   = 8'b0000_0100,
        PH_ADDR   = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_RSTART = 8'b0010_0000,
        PH_SLAR   = 8'b0100_0000,
        PH_RX     = 8'b1000_0000
    } phase_t;

    // One result item.
    typedef struct packed {
        cmd_t       command;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       last;
    } result_t;

    // Depth of the result queue.
    localparam int RES_DEPTH = 4;

endpackage

/* sv/i2c_eeprom_access_sequencer.sv */
// An accepted item passes the input register, then the result queue, on its
// way to m_. Throughput: one item per cycle while the queue has room for two
// results; an item that ends an access gives two results, and the four-entry
// result queue drains one result per cycle while m_tready is high.
// Reset: aresetn low at a rising edge returns the sequencer to idle and
// empties the input register and the result queue.
// ---------------------------------------------------------------------------
// I2C EEPROM access sequencer
// Drives byte writes and random byte reads on a 2 KB serial EEPROM through
// a byte-level I2C master, one bus step per status report.
// ---------------------------------------------------------------------------
module i2c_eeprom_access_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: mem_address[10:0], write_data[18:11], bus_status[26:19],
    //        rx_data[34:27], zero fill[39:35]
    input  logic [39:0] s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: tx_byte[7:0], read_data[15:8]
    output logic [15:0] m_tdata,
    // tuser: command[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import i2cea_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [10:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  status_reg;
    logic [7:0]  rx_reg;

    // Sequencer state.
    phase_t      phase_reg, phase_next;
    logic        write_kind_reg, write_kind_next;
    logic [10:0] held_address_reg, held_address_next;
    logic [7:0]  held_data_reg, held_data_next;

    // Result queue.
    result_t            res_q_reg [RES_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic        fire;
    logic        pop;
    logic        in_take;
    logic [1:0]  n_res;
    result_t     res0, res1;
    logic [7:0]  dev_byte;
    logic [7:0]  expected;
    logic        status_ok;

    // An item is processed once the queue has room for two results.
    assign fire     = in_valid_reg && (count_reg <= CNT_W'(RES_DEPTH - 2));
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    // Device address byte with the three block bits of the word address.
    assign dev_byte = DEV_BASE + {4'b0000, held_address_reg[10:8], 1'b0};

    // Status code that the current phase waits for.
    always_comb begin
        case (phase_reg)
            PH_START:  expected = ST_START;
            PH_SLAW:   expected = ST_SLAW_OK;
            PH_ADDR:   expected = ST_DATA_OK;
            PH_DATA:   expected = ST_DATA_OK;
            PH_RSTART: expected = ST_RSTART;
            PH_SLAR:   expected = ST_SLAR_OK;
            PH_RX:     expected = ST_RX_NACK;
            default:   expected = 8'h00;
        endcase
    end

    assign status_ok = ((status_reg & STATUS_MASK) == expected) && (phase_reg != PH_IDLE);

    // Next state and results for the item in the input register.
    always_comb begin
        phase_next        = phase_reg;
        write_kind_next   = write_kind_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        n_res             = 2'd0;
        res0              = '{command: CMD_START, tx_byte: 8'h00, read_data: 8'h00, last: 1'b1};
        res1              = '{command: CMD_DONE, tx_byte: 8'h00, read_data: 8'h00, last: 1'b1};
        if (op_reg == OP_READ || op_reg == OP_WRITE) begin
            n_res = 2'd1;
            if (phase_reg != PH_IDLE) begin
                res0.command = CMD_REJECT;
            end else begin
                write_kind_next   = op_reg[0];
                held_address_next = addr_reg;
                held_data_next    = (op_reg == OP_WRITE) ? wdata_reg : 8'h00;
                phase_next        = PH_START;
            end
        end else if (op_reg == OP_STATUS && status_ok) begin
            n_res = 2'd1;
            case (phase_reg)
                PH_START: begin
                    phase_next    = PH_SLAW;
                    res0.command  = CMD_TX;
                    res0.tx_byte  = dev_byte;
                end
                PH_SLAW: begin
                    phase_next    = PH_ADDR;
                    res0.command  = CMD_TX;
                    res0.tx_byte  = held_address_reg[7:0];
                end
                PH_ADDR: begin
                    if (write_kind_reg) begin
                        phase_next   = PH_DATA;
                        res0.command = CMD_TX;
                        res0.tx_byte = held_data_reg;
                    end else begin
                        phase_next   = PH_RSTART;
                    end
                end
                PH_DATA: begin
                    phase_next   = PH_IDLE;
                    n_res        = 2'd2;
                    res0.command = CMD_STOP;
                    res0.last    = 1'b0;
                end
                PH_RSTART: begin
                    phase_next   = PH_SLAR;
                    res0.command = CMD_TX;
                    res0.tx_byte = dev_byte + 8'd1;
                end
                PH_SLAR: begin
                    phase_next   = PH_RX;
                    res0.command = CMD_RXNACK;
                end
                PH_RX: begin
                    phase_next     = PH_IDLE;
                    held_data_next = rx_reg;
                    n_res          = 2'd2;
                    res0.command   = CMD_STOP;
                    res0.last      = 1'b0;
                    res1.read_data = rx_reg;
                end
                default: begin
                    phase_next = PH_IDLE;
                    n_res      = 2'd0;
                end
            endcase
        end
    end

    // Input register and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            phase_reg      <= PH_IDLE;
            write_kind_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                phase_reg      <= phase_next;
                write_kind_reg <= write_kind_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            op_reg     <= s_tuser;
            addr_reg   <= s_tdata[10:0];
            wdata_reg  <= s_tdata[18:11];
            status_reg <= s_tdata[26:19];
            rx_reg     <= s_tdata[34:27];
        end
        if (fire) begin
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (fire) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            count_reg <= count_reg + (fire ? CNT_W'(n_res) : CNT_W'(0))
                         - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Result queue entries; the second result of an item goes behind the first.
    always_ff @(posedge aclk) begin
        if (fire && n_res != 2'd0) begin
            res_q_reg[wr_ptr_reg] <= res0;
        end
        if (fire && n_res == 2'd2) begin
            res_q_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Result channel driven from the queue head.
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = res_q_reg[rd_ptr_reg].command;
    assign m_tdata  = {res_q_reg[rd_ptr_reg].read_data, res_q_reg[rd_ptr_reg].tx_byte};
    assign m_tlast  = res_q_reg[rd_ptr_reg].last;

endmodule

/* bench/i2c_eeprom_access_sequencer_tb.sv */
// ---------------------------------------------------------------------------
// I2C EEPROM access sequencer testbench
// Opens with a short table of directed items: idle reports, the spare op
// code, requests while busy, masked status codes, full write and read
// accesses at extreme and middle addresses. Random accesses with noise follow, under
// several idling and stalling patterns, with one long receiver hold-off.
// Every result item is checked field by field against typed or predicted expectations.
// ---------------------------------------------------------------------------
module i2c_eeprom_access_sequencer_tb;
    import i2cea_pkg::*;

    // Op code that the sequencer has no use for.
    localparam logic [1:0] OP_SPARE = 2'd3;
    // Marks a directed row whose results come from the predictor.
    localparam int FROM_MODEL = -1;
    localparam int TARGET_ITEMS = 1000;
    localparam int HOLD_CYCLES = 300;

    // One directed row: input fields and, where typed, its expected results.
    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  status;
        logic [7:0]  rx;
        int          n_typed;
        cmd_t        first_cmd;
        logic [7:0]  done_data;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_READ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Predictor state.
    phase_t      seq_phase = PH_IDLE;
    logic        seq_write = 1'b0;
    logic [10:0] seq_addr = '0;
    logic [7:0]  seq_data = '0;

    result_t     expected_results[$];
    dir_row_t    dir_rows[$];

    int err_count = 0;
    int items_sent = 0;
    int items_ignored = 0;
    int results_seen = 0;
    int accesses_done = 0;
    int reads_done = 0;
    int rejects_seen = 0;

    // Idling controls; the receiver side ones are written with nonblocking
    // assignments because its process samples them at the clock edge.
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    always #5 aclk = ~aclk;

    i2c_eeprom_access_sequencer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Status code awaited in each phase; idle awaits nothing.
    function automatic logic [8:0] awaited_status(input phase_t ph);
        case (ph)
            PH_START:  return {1'b0, ST_START};
            PH_SLAW:   return {1'b0, ST_SLAW_OK};
            PH_ADDR:   return {1'b0, ST_DATA_OK};
            PH_DATA:   return {1'b0, ST_DATA_OK};
            PH_RSTART: return {1'b0, ST_RSTART};
            PH_SLAR:   return {1'b0, ST_SLAR_OK};
            PH_RX:     return {1'b0, ST_RX_NACK};
            default:   return 9'h100;
        endcase
    endfunction

    // Advances the predicted sequencer by one item and gives its results.
    function automatic int advance_sequencer(input logic [1:0] op,
                                             input logic [10:0] addr,
                                             input logic [7:0] wdata,
                                             input logic [7:0] status,
                                             input logic [7:0] rx,
                                             output result_t res0,
                                             output result_t res1);
        int n;
        logic [7:0] dev;
        n = 0;
        res0.command = CMD_START;
        res0.tx_byte = 8'h00;
        res0.read_data = 8'h00;
        res0.last = 1'b1;
        res1 = res0;
        res1.command = CMD_DONE;
        dev = DEV_BASE + {4'b0000, seq_addr[10:8], 1'b0};
        if (op == OP_READ || op == OP_WRITE) begin
            n = 1;
            if (seq_phase != PH_IDLE) begin
                res0.command = CMD_REJECT;
                rejects_seen++;
            end else begin
                seq_write = (op == OP_WRITE);
                seq_addr = addr;
                seq_data = (op == OP_WRITE) ? wdata : 8'h00;
                seq_phase = PH_START;
            end
        end else if (op == OP_STATUS && seq_phase != PH_IDLE &&
                     {1'b0, status & STATUS_MASK} == awaited_status(seq_phase)) begin
            n = 1;
            case (seq_phase)
                PH_START: begin
                    seq_phase = PH_SLAW;
                    res0.command = CMD_TX;
                    res0.tx_byte = dev;
                end
                PH_SLAW: begin
                    seq_phase = PH_ADDR;
                    res0.command = CMD_TX;
                    res0.tx_byte = seq_addr[7:0];
                end
                PH_ADDR: begin
                    if (seq_write) begin
                        seq_phase = PH_DATA;
                        res0.command = CMD_TX;
                        res0.tx_byte = seq_data;
                    end else begin
                        seq_phase = PH_RSTART;
                    end
                end
                PH_RSTART: begin
                    seq_phase = PH_SLAR;
                    res0.command = CMD_TX;
                    res0.tx_byte = dev + 8'h01;
                end
                PH_SLAR: begin
                    seq_phase = PH_RX;
                    res0.command = CMD_RXNACK;
                end
                default: begin
                    // Final acknowledge of a write, or the received byte of
                    // a read: stop the bus and report done.
                    if (seq_phase == PH_RX) begin
                        seq_data = rx;
                        res1.read_data = rx;
                        reads_done++;
                    end
                    seq_phase = PH_IDLE;
                    res0.command = CMD_STOP;
                    res0.last = 1'b0;
                    accesses_done++;
                    n = 2;
                end
            endcase
        end
        return n;
    endfunction

    // Adds one row to the directed table.
    task automatic add_row(input logic [1:0] op, input logic [10:0] addr,
                           input logic [7:0] wdata, input logic [7:0] status,
                           input logic [7:0] rx, input int n_typed,
                           input cmd_t first_cmd, input logic [7:0] done_data);
        dir_row_t r;
        r.op = op;
        r.addr = addr;
        r.wdata = wdata;
        r.status = status;
        r.rx = rx;
        r.n_typed = n_typed;
        r.first_cmd = first_cmd;
        r.done_data = done_data;
        dir_rows.push_back(r);
    endtask

    // Offers one item, waits until it is accepted, then queues the expected
    // results, typed ones where given and predicted ones otherwise.
    task automatic send_and_predict(input logic [1:0] op, input logic [10:0] addr,
                                    input logic [7:0] wdata, input logic [7:0] status,
                                    input logic [7:0] rx, input int n_typed,
                                    input cmd_t first_cmd, input logic [7:0] done_data);
        result_t r0;
        result_t r1;
        int n;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b00000, rx, status, wdata, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = advance_sequencer(op, addr, wdata, status, rx, r0, r1);
        items_sent++;
        if (n == 0) items_ignored++;
        if (n_typed != FROM_MODEL) begin
            n = n_typed;
            r0.command = (n == 2) ? CMD_STOP : first_cmd;
            r0.tx_byte = 8'h00;
            r0.read_data = 8'h00;
            r0.last = (n == 1);
            r1.command = CMD_DONE;
            r1.tx_byte = 8'h00;
            r1.read_data = done_data;
            r1.last = 1'b1;
        end
        if (n >= 1) expected_results.push_back(r0);
        if (n == 2) expected_results.push_back(r1);
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: cmd %0d tdata %h",
                                          m_tuser, m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser != want.command)
                    report_mismatch($sformatf("command %0d, expected %0d",
                                              m_tuser, want.command));
                if (m_tdata[7:0] != want.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, expected %h",
                                              m_tdata[7:0], want.tx_byte));
                if (m_tdata[15:8] != want.read_data)
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              m_tdata[15:8], want.read_data));
                if (m_tlast != want.last)
                    report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
            end
        end
    end

    // Stimulus: directed table, then random accesses over four idling phases.
    initial begin : stimulus
        logic [1:0]  op;
        logic [10:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  status;
        logic [7:0]  rx;
        int          stage;

        // Reports while idle and the spare op code are ignored.
        add_row(OP_STATUS, 11'h000, 8'h00, ST_START, 8'h00, 0, CMD_START, 8'h00);
        add_row(OP_SPARE, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 0, CMD_START, 8'h00);
        // Write to the top address with all-ones data.
        add_row(OP_WRITE, 11'h7FF, 8'hFF, 8'h00, 8'h00, 1, CMD_START, 8'h00);
        add_row(OP_WRITE, 11'h000, 8'h00, 8'h00, 8'h00, 1, CMD_REJECT, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, 8'h00, 8'h00, 0, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_START | 8'h07, 8'h00,
                FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_SLAW_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_DATA_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_READ, 11'h2AA, 8'h55, 8'h00, 8'h00, 1, CMD_REJECT, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_DATA_OK | 8'h07, 8'h00, 2, CMD_STOP, 8'h00);
        // Read from address zero, returning all ones.
        add_row(OP_READ, 11'h000, 8'hFF, 8'h00, 8'h00, 1, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_START, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_SLAW_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_DATA_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_START, 8'h00, 0, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_RSTART, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_SLAR_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_RX_NACK, 8'hFF, 2, CMD_STOP, 8'hFF);
        // Read from the middle block, returning zero after a wrong code.
        add_row(OP_READ, 11'h400, 8'h00, 8'h00, 8'h00, 1, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_START, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_SLAW_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_DATA_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_RSTART, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_SLAR_OK, 8'h00, FROM_MODEL, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, 8'hFF, 8'h00, 0, CMD_START, 8'h00);
        add_row(OP_STATUS, 11'h000, 8'h00, ST_RX_NACK, 8'h00, 2, CMD_STOP, 8'h00);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_and_predict(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].wdata,
                             dir_rows[i].status, dir_rows[i].rx, dir_rows[i].n_typed,
                             dir_rows[i].first_cmd, dir_rows[i].done_data);

        // Random part: mostly well-formed accesses, some noise.
        while (items_sent - items_ignored < TARGET_ITEMS) begin
            stage = (items_sent - items_ignored) * 4 / TARGET_ITEMS;
            case (stage)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 55;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 55;
                end
                default: begin
                    tx_idle_pct = 29;
                    rx_stall_pct <= 29;
                end
            endcase
            // Long hold-off while the sender keeps offering items.
            if (items_sent - items_ignored >= 100 && !hold_go) hold_go <= 1'b1;

            op = OP_STATUS;
            addr = 11'($urandom_range(2047));
            wdata = 8'($urandom_range(255));
            rx = 8'($urandom_range(255));
            status = 8'($urandom_range(255));
            if ($urandom_range(99) < 15) begin
                op = 2'($urandom_range(3));
            end else if (seq_phase == PH_IDLE) begin
                op = $urandom_range(1) ? OP_WRITE : OP_READ;
            end else if ($urandom_range(99) >= 10) begin
                status = 8'(awaited_status(seq_phase)) | 8'($urandom_range(7));
            end
            send_and_predict(op, addr, wdata, status, rx, FROM_MODEL, CMD_START, 8'h00);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency for any stray result.
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d items (%0d ignored) and checked %0d result items.",
                 items_sent, items_ignored, results_seen);
        $display("%0d accesses completed, %0d of them reads; %0d requests rejected as busy.",
                 accesses_done, reads_done, rejects_seen);
        if (err_count == 0) begin
            $display("i2c_eeprom_access_sequencer_tb passed");
        end else begin
            $display("i2c_eeprom_access_sequencer_tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("i2c_eeprom_access_sequencer_tb failed");
        $finish;
    end

endmodule
